@@ sv/cpu8x_pkg.sv @@
// ----------------------------------------------------------------------------
// cpu8x_pkg
// types, opcodes and flag positions shared by the opcode executor
// ----------------------------------------------------------------------------
package cpu8x_pkg;

    // opcodes of the first row of the opcode map that do work
    localparam logic [7:0] OP_LXI_B  = 8'h01;
    localparam logic [7:0] OP_STAX_B = 8'h02;
    localparam logic [7:0] OP_INX_B  = 8'h03;
    localparam logic [7:0] OP_INR_B  = 8'h04;
    localparam logic [7:0] OP_DCR_B  = 8'h05;
    localparam logic [7:0] OP_MVI_B  = 8'h06;
    localparam logic [7:0] OP_RLC    = 8'h07;
    localparam logic [7:0] OP_DAD_B  = 8'h09;
    localparam logic [7:0] OP_LDAX_B = 8'h0A;
    localparam logic [7:0] OP_DCX_B  = 8'h0B;
    localparam logic [7:0] OP_INR_C  = 8'h0C;
    localparam logic [7:0] OP_DCR_C  = 8'h0D;
    localparam logic [7:0] OP_MVI_C  = 8'h0E;
    localparam logic [7:0] OP_RRC    = 8'h0F;

    // flag byte bit positions
    localparam int unsigned FL_S  = 7;
    localparam int unsigned FL_Z  = 6;
    localparam int unsigned FL_AC = 4;
    localparam int unsigned FL_P  = 2;
    localparam int unsigned FL_CY = 0;

    // machine cycle counts
    localparam logic [3:0] CYC_4  = 4'd4;
    localparam logic [3:0] CYC_5  = 4'd5;
    localparam logic [3:0] CYC_7  = 4'd7;
    localparam logic [3:0] CYC_10 = 4'd10;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  reg_b_out;
        logic [7:0]  reg_c_out;
        logic [7:0]  reg_h_out;
        logic [7:0]  reg_l_out;
        logic [7:0]  flags_out;
        logic [15:0] pc_out;
        logic [3:0]  cycles_taken;
        logic        mem_write;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
    } t_out_item;

    // architectural registers
    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [7:0]  f;
        logic [15:0] pc;
    } t_cpu_state;

    // side effects of one instruction
    typedef struct packed {
        logic [3:0] cycles;
        logic       mem_wr;
        logic       mem_rd;
    } t_exec_ctl;

endpackage

@@ sv/cpu8x_dmem.sv @@
// ----------------------------------------------------------------------------
// cpu8x_dmem
// data memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module cpu8x_dmem #(
    parameter int ADDR_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [7:0]           i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [7:0]           o_rdata
);

    logic [7:0] r_mem [2**ADDR_BITS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/cpu8x_exec.sv @@
// ----------------------------------------------------------------------------
// cpu8x_exec
// next register state and side effects of one instruction
// ----------------------------------------------------------------------------
module cpu8x_exec
    import cpu8x_pkg::*;
(
    input  t_cpu_state i_st,
    input  t_in_item   i_item,
    output t_cpu_state o_nx,
    output t_exec_ctl  o_ctl
);

    // inr/dcr flag update, carry kept
    function automatic logic [7:0] step_flags(input logic [7:0] f_old,
                                              input logic [7:0] r,
                                              input logic       ac);
        logic [7:0] f;
        f         = f_old;
        f[FL_S]   = r[7];
        f[FL_Z]   = (r == 8'h00);
        f[FL_AC]  = ac;
        f[FL_P]   = ~(^r);
        return f;
    endfunction

    logic [15:0] bc;
    logic [15:0] hl;
    logic [16:0] sum;
    logic [15:0] bc_inc;
    logic [15:0] bc_dec;
    logic [7:0]  b_inc, b_dec, c_inc, c_dec;
    logic [1:0]  len;

    assign bc     = {i_st.b, i_st.c};
    assign hl     = {i_st.h, i_st.l};
    assign sum    = {1'b0, bc} + {1'b0, hl};
    assign bc_inc = bc + 16'd1;
    assign bc_dec = bc - 16'd1;
    assign b_inc  = i_st.b + 8'd1;
    assign b_dec  = i_st.b - 8'd1;
    assign c_inc  = i_st.c + 8'd1;
    assign c_dec  = i_st.c - 8'd1;

    always_comb begin
        o_nx         = i_st;
        o_ctl.cycles = CYC_4;
        o_ctl.mem_wr = 1'b0;
        o_ctl.mem_rd = 1'b0;
        len          = 2'd1;
        unique case (i_item.opcode)
            OP_LXI_B: begin
                o_nx.c       = i_item.imm_low;
                o_nx.b       = i_item.imm_high;
                len          = 2'd3;
                o_ctl.cycles = CYC_10;
            end
            OP_STAX_B: begin
                o_ctl.mem_wr = 1'b1;
                o_ctl.cycles = CYC_7;
            end
            OP_INX_B: begin
                {o_nx.b, o_nx.c} = bc_inc;
                o_ctl.cycles     = CYC_5;
            end
            OP_INR_B: begin
                o_nx.b       = b_inc;
                o_nx.f       = step_flags(i_st.f, b_inc, i_st.b[3:0] == 4'hF);
                o_ctl.cycles = CYC_5;
            end
            OP_DCR_B: begin
                o_nx.b       = b_dec;
                o_nx.f       = step_flags(i_st.f, b_dec, i_st.b[3:0] == 4'h0);
                o_ctl.cycles = CYC_5;
            end
            OP_MVI_B: begin
                o_nx.b       = i_item.imm_low;
                len          = 2'd2;
                o_ctl.cycles = CYC_7;
            end
            OP_RLC: begin
                o_nx.f[FL_CY] = i_st.a[7];
                o_nx.a        = {i_st.a[6:0], i_st.a[7]};
            end
            OP_DAD_B: begin
                {o_nx.h, o_nx.l} = sum[15:0];
                o_nx.f[FL_CY]    = sum[16];
                o_ctl.cycles     = CYC_10;
            end
            OP_LDAX_B: begin
                // accumulator arrives from the memory read port
                o_ctl.mem_rd = 1'b1;
                o_ctl.cycles = CYC_7;
            end
            OP_DCX_B: begin
                {o_nx.b, o_nx.c} = bc_dec;
                o_ctl.cycles     = CYC_5;
            end
            OP_INR_C: begin
                o_nx.c       = c_inc;
                o_nx.f       = step_flags(i_st.f, c_inc, i_st.c[3:0] == 4'hF);
                o_ctl.cycles = CYC_5;
            end
            OP_DCR_C: begin
                o_nx.c       = c_dec;
                o_nx.f       = step_flags(i_st.f, c_dec, i_st.c[3:0] == 4'h0);
                o_ctl.cycles = CYC_5;
            end
            OP_MVI_C: begin
                o_nx.c       = i_item.imm_low;
                len          = 2'd2;
                o_ctl.cycles = CYC_7;
            end
            OP_RRC: begin
                o_nx.f[FL_CY] = i_st.a[0];
                o_nx.a        = {i_st.a[0], i_st.a[7:1]};
            end
            default: begin
                // nop and every other opcode: one byte, default cycle count
            end
        endcase
        o_nx.pc = i_st.pc + 16'(len);
    end

endmodule

@@ sv/eight_bit_cpu_opcode_exec.sv @@
// ----------------------------------------------------------------------------
// eight_bit_cpu_opcode_exec
// executes 8080 opcodes 0x00-0x0f against A, B, C, H, L, flags, PC and memory
// ----------------------------------------------------------------------------
//
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+-------------------------
// in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
// out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// one item per cycle sustained while results are taken; an accepted item
// passes the input register, then execute into the result register
// after reset a clearing pass zeroes the data memory, during which no
// item is accepted
// a stalled result holds the execute stage; the input register still takes
// one more item, then the input side stalls too
// ldax data comes from the registered memory read port and is forwarded to
// the result and to the next instruction's accumulator
//
module eight_bit_cpu_opcode_exec
    import cpu8x_pkg::*;
#(
    parameter int MEM_ADDR_BITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW = MEM_ADDR_BITS;

    // input register
    logic       r_in_valid;
    t_in_item   r_in;

    // architectural state; r_a_pend marks the accumulator as living in the
    // memory read register after an ldax
    t_cpu_state r_st;
    logic       r_a_pend;

    // result register
    logic       r_out_valid;
    t_out_item  r_out;
    logic       r_out_acc_mem;

    // memory clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    t_cpu_state    st_eff;
    t_cpu_state    nx;
    t_exec_ctl     ctl;
    logic          exec_fire;
    logic          in_fire;
    logic [15:0]   bc;
    logic [7:0]    mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    assign bc = {st_eff.b, st_eff.c};

    // execute when an item waits and the result register frees up
    assign exec_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_busy && (!r_in_valid || exec_fire);
    assign in_fire    = i_in_valid && o_in_ready;

    // accumulator forwarding from the memory read register
    always_comb begin
        st_eff = r_st;
        if (r_a_pend) begin
            st_eff.a = mem_q;
        end
    end

    cpu8x_exec u_exec (
        .i_st   (st_eff),
        .i_item (r_in),
        .o_nx   (nx),
        .o_ctl  (ctl)
    );

    // memory port: clearing pass owns the write side until it is done
    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'h00;
        end else begin
            mem_we    = exec_fire && ctl.mem_wr;
            mem_waddr = bc[AW-1:0];
            mem_wdata = st_eff.a;
        end
    end

    cpu8x_dmem #(
        .ADDR_BITS (AW)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (exec_fire && ctl.mem_rd),
        .i_raddr (bc[AW-1:0]),
        .o_rdata (mem_q)
    );

    // clearing pass sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == {AW{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (exec_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_item;
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= '0;
            r_a_pend <= 1'b0;
        end else if (exec_fire) begin
            r_st     <= nx;
            r_a_pend <= ctl.mem_rd;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out.acc          <= nx.a;
            r_out.reg_b_out    <= nx.b;
            r_out.reg_c_out    <= nx.c;
            r_out.reg_h_out    <= nx.h;
            r_out.reg_l_out    <= nx.l;
            r_out.flags_out    <= nx.f;
            r_out.pc_out       <= nx.pc;
            r_out.cycles_taken <= ctl.cycles;
            r_out.mem_write    <= ctl.mem_wr;
            r_out.mem_address  <= ctl.mem_wr ? bc : 16'h0000;
            r_out.mem_data     <= ctl.mem_wr ? st_eff.a : 8'h00;
            r_out_acc_mem      <= ctl.mem_rd;
        end
    end

    // ldax result takes its accumulator from the read register, which holds
    // while the result waits since no read is issued without execution
    always_comb begin
        o_out_item = r_out;
        if (r_out_acc_mem) begin
            o_out_item.acc = mem_q;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
